>>> rtl/lchs_pkg.sv
// Shared types and constants for the longest common substring hash block.
// Used by every module under rtl except lchs_ram; depends on nothing.
package lchs_pkg;

   localparam int MAX_LEN   = 256;
   localparam int ADDR_W    = $clog2(MAX_LEN);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int CHAR_W    = 8;
   localparam int HASH_W    = 64;
   localparam int HALF_W    = HASH_W / 2;
   localparam int PCT_SCALE = 25600;
   localparam int NUM_W     = $clog2(PCT_SCALE * MAX_LEN + 1);
   localparam int DCNT_W    = $clog2(NUM_W);
   localparam int PCT_W     = 15;

   localparam logic [1:0] ACT_FIRST   = 2'd0;
   localparam logic [1:0] ACT_SECOND  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   localparam logic [HASH_W-1:0] HASH_BASE_RESET = HASH_W'(31);

   typedef struct packed {
      logic [1:0]        action;
      logic [CHAR_W-1:0] char_code;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] common_length;
      logic [CNT_W-1:0] longer_length;
      logic [PCT_W-1:0] percent_q8;
      logic             empty_flag;
      logic             overflow_flag;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_POW, S_POW_WAIT, S_PRE_CHK, S_PRE_RD, S_PRE_ACC,
      S_SRCH_INIT, S_SRCH, S_WIN_RD1, S_WIN_RD2, S_WIN_SUB, S_WIN_WAIT,
      S_CMP_RD, S_CMP_CHK, S_DIV, S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_APPEND, OP_START, OP_POW, OP_POW_NEXT, OP_PRE_SKIP, OP_PRE_ACC,
      OP_SRCH_INIT, OP_MID, OP_WIN_ADDR, OP_WIN_LATCH, OP_WIN_STORE, OP_WIN_HASH,
      OP_HIT, OP_MISS, OP_CMP_NEXT, OP_NEXT_POS, OP_DIV_INIT, OP_DIV_STEP, OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   mul_start;
   } cmd_type;

   typedef struct packed {
      logic longer_zero;
      logic pow_last;
      logic cnt_zero;
      logic pre_last;
      logic sel;
      logic srch_more;
      logic win_last;
      logic cmp_hit;
      logic cmp_last;
      logic mul_done;
      logic div_last;
      logic rsp_busy;
   } stat_type;

endpackage

>>> rtl/longest_common_substring_hash.sv
// Longest common substring by binary search over 64-bit polynomial window
// hashes. Requests with action 0 or 1 append a byte to the first or second
// string (up to 256 each; extra bytes are dropped and flagged); action 3 is
// ignored. A compute request (action 2) builds the power table (one entry
// per character of the longer length, using the shared 32x32 multiplier),
// prefix hashes, then runs about log2(shorter+1) probes of length k, each
// hashing every window of both strings and comparing windows (worst case
// the product of the two window counts), and a divide for percent_q8. One
// result then appears on rsp; loads are still taken while it waits, a new
// compute is held until it is taken.
// Depends on lchs_pkg, lchs_ctrl and lchs_dp.
module longest_common_substring_hash (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lchs_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lchs_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [lchs_pkg::HASH_W-1:0] csr_wr_data
);
   import lchs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the work
   lchs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .stat       (stat),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   // hold strings, hashes and the result register
   lchs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_compute_over_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == ACT_COMPUTE) |-> !rsp_valid)
      else $error("compute taken while a result was pending");

   a_common_within_longer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.common_length <= rsp_data.longer_length))
      else $error("common length exceeds longer length");

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_flag) |->
      (rsp_data.longer_length == '0 && rsp_data.percent_q8 == '0))
      else $error("empty flag with nonzero length");
`endif

endmodule

>>> rtl/lchs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module lchs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lchs_mul.sv
// Multicycle 64x64 multiplier, low half of the product, one 32x32 multiplier.
// Depends on lchs_pkg.
module lchs_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lchs_pkg::HASH_W-1:0]  a,
   input  logic [lchs_pkg::HASH_W-1:0]  b,
   output logic                         done,
   output logic [lchs_pkg::HASH_W-1:0]  result
);
   import lchs_pkg::*;

   logic [HASH_W-1:0] a_ff, a_in, b_ff, b_in, p_ff, p_in, acc_ff, acc_in;
   logic [1:0]        sq_ff, sq_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [HALF_W-1:0] op_a, op_b;

   // partial products: lo*lo, lo*hi, hi*lo
   assign op_a = (sq_ff == 2'd2) ? a_ff[HASH_W-1:HALF_W] : a_ff[HALF_W-1:0];
   assign op_b = (sq_ff == 2'd1) ? b_ff[HASH_W-1:HALF_W] : b_ff[HALF_W-1:0];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         sq_in   = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in  = op_a * op_b;
         sq_in = sq_ff + 2'd1;
         unique case (sq_ff)
            2'd0: begin
            end
            2'd1: acc_in = p_ff;
            2'd2: acc_in = acc_ff + {p_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            default: begin
               acc_in  = acc_ff + {p_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

>>> rtl/lchs_dp.sv
// Datapath: string and hash memories, counters, multiplier and divider.
// Depends on lchs_pkg, lchs_ram and lchs_mul.
module lchs_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  lchs_pkg::cmd_type           cmd,
   input  lchs_pkg::req_type           req_data,
   input  logic                        csr_wr_en,
   input  logic [lchs_pkg::HASH_W-1:0] csr_wr_data,
   output lchs_pkg::stat_type          stat,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lchs_pkg::rsp_type           rsp_data
);
   import lchs_pkg::*;

   logic [HASH_W-1:0] base_ff;
   logic [CNT_W-1:0]  cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic              drop_ff, drop_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, pos_ff, pos_in, cmp_ff, cmp_in;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic              sel_ff, sel_in;
   logic [HASH_W-1:0] p_ff, p_in, acc_ff, acc_in, a_ff, a_in, pw_ff, pw_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [NUM_W-1:0]  num_ff, num_in, quot_ff, quot_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  longer, shorter, top, cnt_sel;
   logic [CNT_W:0]    mid_sum, trial;
   logic [HASH_W+CHAR_W-1:0] pre_prod;
   logic [HASH_W-1:0] pre_sum;
   logic [CNT_W-1:0]  pre_addr9, pow_addr9;

   logic              c1_we, c2_we, p1_we, p2_we, pow_we, win_we;
   logic [CHAR_W-1:0] c1_rd, c2_rd, char_rd;
   logic [HASH_W-1:0] p1_rd, p2_rd, pre_rd, pow_rd, win_rd;

   logic              mul_done;
   logic [HASH_W-1:0] mul_a, mul_b, mul_res;

   assign longer  = (cnt1_ff > cnt2_ff) ? cnt1_ff : cnt2_ff;
   assign shorter = (cnt1_ff > cnt2_ff) ? cnt2_ff : cnt1_ff;
   assign top     = longer - CNT_W'(1);
   assign cnt_sel = sel_ff ? cnt2_ff : cnt1_ff;
   assign char_rd = sel_ff ? c2_rd : c1_rd;
   assign pre_rd  = sel_ff ? p2_rd : p1_rd;
   assign pre_prod = pow_rd * char_rd;
   assign pre_sum = acc_ff + pre_prod[HASH_W-1:0];
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign trial   = {rem_ff, num_ff[NUM_W-1]};

   // window end address first, then the prefix just before the window
   assign pre_addr9 = (cmd.op == OP_WIN_ADDR) ? (pos_ff + mid_ff - CNT_W'(1))
                                               : (pos_ff - CNT_W'(1));
   assign pow_addr9 = (cmd.op == OP_WIN_ADDR) ? (top - pos_ff) : idx_ff;

   assign mul_a = (cmd.op == OP_POW) ? p_ff
                : (a_ff - ((pos_ff != '0) ? pre_rd : '0));
   assign mul_b = (cmd.op == OP_POW) ? base_ff : pw_ff;

   assign stat.longer_zero = (longer == '0);
   assign stat.pow_last    = (idx_ff == top);
   assign stat.cnt_zero    = (cnt_sel == '0);
   assign stat.pre_last    = (idx_ff == cnt_sel - CNT_W'(1));
   assign stat.sel         = sel_ff;
   assign stat.srch_more   = ((hi_ff - lo_ff) > CNT_W'(1));
   assign stat.win_last    = (pos_ff == cnt_sel - mid_ff);
   assign stat.cmp_hit     = (win_rd == h_ff);
   assign stat.cmp_last    = (cmp_ff == cnt1_ff - mid_ff);
   assign stat.mul_done    = mul_done;
   assign stat.div_last    = (dcnt_ff == DCNT_W'(NUM_W - 1));
   assign stat.rsp_busy    = rsp_valid_ff;

   always_comb begin
      cnt1_in = cnt1_ff;   cnt2_in = cnt2_ff;   drop_in = drop_ff;
      idx_in  = idx_ff;    pos_in  = pos_ff;    cmp_in  = cmp_ff;
      lo_in   = lo_ff;     hi_in   = hi_ff;     mid_in  = mid_ff;
      sel_in  = sel_ff;    p_in    = p_ff;      acc_in  = acc_ff;
      a_in    = a_ff;      pw_in   = pw_ff;     h_in    = h_ff;
      num_in  = num_ff;    quot_in = quot_ff;   rem_in  = rem_ff;
      dcnt_in = dcnt_ff;   rsp_in  = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      c1_we = 1'b0; c2_we = 1'b0; p1_we = 1'b0; p2_we = 1'b0;
      pow_we = 1'b0; win_we = 1'b0;
      unique case (cmd.op)
         OP_APPEND: begin
            if (req_data.action == ACT_FIRST) begin
               if (cnt1_ff < CNT_W'(MAX_LEN)) begin
                  c1_we   = 1'b1;
                  cnt1_in = cnt1_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end else begin
               if (cnt2_ff < CNT_W'(MAX_LEN)) begin
                  c2_we   = 1'b1;
                  cnt2_in = cnt2_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         OP_START: begin
            lo_in   = '0;
            quot_in = '0;
            idx_in  = '0;
            p_in    = HASH_W'(1);
         end
         OP_POW: begin
            pow_we = 1'b1;
            if (stat.pow_last) begin
               idx_in = '0;
               acc_in = '0;
               sel_in = 1'b0;
            end
         end
         OP_POW_NEXT: begin
            p_in   = mul_res;
            idx_in = idx_ff + CNT_W'(1);
         end
         OP_PRE_SKIP: begin
            sel_in = 1'b1;
            idx_in = '0;
            acc_in = '0;
         end
         OP_PRE_ACC: begin
            acc_in = pre_sum;
            p1_we  = !sel_ff;
            p2_we  = sel_ff;
            if (stat.pre_last) begin
               // restart the running sum for the second string
               idx_in = '0;
               sel_in = 1'b1;
               acc_in = '0;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         OP_SRCH_INIT: hi_in = shorter + CNT_W'(1);
         OP_MID: begin
            mid_in = mid_sum[CNT_W:1];
            sel_in = 1'b0;
            pos_in = '0;
         end
         OP_WIN_ADDR: begin
         end
         OP_WIN_LATCH: begin
            a_in  = pre_rd;
            pw_in = pow_rd;
         end
         OP_WIN_STORE: begin
            win_we = 1'b1;
            if (stat.win_last) begin
               pos_in = '0;
               sel_in = 1'b1;
            end else begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end
         OP_WIN_HASH: begin
            h_in   = mul_res;
            cmp_in = '0;
         end
         OP_HIT:      lo_in  = mid_ff;
         OP_MISS:     hi_in  = mid_ff;
         OP_CMP_NEXT: cmp_in = cmp_ff + CNT_W'(1);
         OP_NEXT_POS: pos_in = pos_ff + CNT_W'(1);
         OP_DIV_INIT: begin
            num_in  = NUM_W'(lo_ff) * NUM_W'(PCT_SCALE);
            rem_in  = '0;
            dcnt_in = '0;
            quot_in = '0;
         end
         OP_DIV_STEP: begin
            num_in  = {num_ff[NUM_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (trial >= {1'b0, longer}) begin
               rem_in  = CNT_W'(trial - {1'b0, longer});
               quot_in = {quot_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[CNT_W-1:0];
               quot_in = {quot_ff[NUM_W-2:0], 1'b0};
            end
         end
         OP_FINISH: begin
            rsp_in.common_length = lo_ff;
            rsp_in.longer_length = longer;
            rsp_in.percent_q8    = quot_ff[PCT_W-1:0];
            rsp_in.empty_flag    = (longer == '0);
            rsp_in.overflow_flag = drop_ff;
            rsp_valid_in = 1'b1;
            cnt1_in = '0;
            cnt2_in = '0;
            drop_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= HASH_BASE_RESET;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;   pos_ff <= pos_in;   cmp_ff <= cmp_in;
      lo_ff  <= lo_in;    hi_ff  <= hi_in;    mid_ff <= mid_in;
      sel_ff <= sel_in;   p_ff   <= p_in;     acc_ff <= acc_in;
      a_ff   <= a_in;     pw_ff  <= pw_in;    h_ff   <= h_in;
      num_ff <= num_in;   quot_ff <= quot_in; rem_ff <= rem_in;
      dcnt_ff <= dcnt_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lchs_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   lchs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_chars1 (
      .clock(clock), .wr_en(c1_we), .wr_addr(cnt1_ff[ADDR_W-1:0]),
      .wr_data(req_data.char_code), .rd_addr(idx_ff[ADDR_W-1:0]), .rd_data(c1_rd)
   );

   lchs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_chars2 (
      .clock(clock), .wr_en(c2_we), .wr_addr(cnt2_ff[ADDR_W-1:0]),
      .wr_data(req_data.char_code), .rd_addr(idx_ff[ADDR_W-1:0]), .rd_data(c2_rd)
   );

   lchs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pre1 (
      .clock(clock), .wr_en(p1_we), .wr_addr(idx_ff[ADDR_W-1:0]),
      .wr_data(pre_sum), .rd_addr(pre_addr9[ADDR_W-1:0]), .rd_data(p1_rd)
   );

   lchs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pre2 (
      .clock(clock), .wr_en(p2_we), .wr_addr(idx_ff[ADDR_W-1:0]),
      .wr_data(pre_sum), .rd_addr(pre_addr9[ADDR_W-1:0]), .rd_data(p2_rd)
   );

   lchs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pow (
      .clock(clock), .wr_en(pow_we), .wr_addr(idx_ff[ADDR_W-1:0]),
      .wr_data(p_ff), .rd_addr(pow_addr9[ADDR_W-1:0]), .rd_data(pow_rd)
   );

   lchs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_win (
      .clock(clock), .wr_en(win_we), .wr_addr(pos_ff[ADDR_W-1:0]),
      .wr_data(mul_res), .rd_addr(cmp_ff[ADDR_W-1:0]), .rd_data(win_rd)
   );

endmodule

>>> rtl/lchs_ctrl.sv
// Controller state machine: sequences loading, hashing, search and divide.
// Depends on lchs_pkg.
module lchs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_action,
   input  lchs_pkg::stat_type stat,
   output logic               req_ready,
   output lchs_pkg::cmd_type  cmd
);
   import lchs_pkg::*;

   state_type state_ff, state_in;
   logic      fire;

   assign fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (fire && req_action == ACT_COMPUTE) state_in = S_START;
         S_START:     state_in = stat.longer_zero ? S_FINISH : S_POW;
         S_POW:       state_in = stat.pow_last ? S_PRE_CHK : S_POW_WAIT;
         S_POW_WAIT:  if (stat.mul_done) state_in = S_POW;
         S_PRE_CHK: begin
            if (stat.cnt_zero) begin
               state_in = stat.sel ? S_SRCH_INIT : S_PRE_CHK;
            end else begin
               state_in = S_PRE_RD;
            end
         end
         S_PRE_RD:    state_in = S_PRE_ACC;
         S_PRE_ACC: begin
            if (stat.pre_last) begin
               state_in = stat.sel ? S_SRCH_INIT : S_PRE_CHK;
            end else begin
               state_in = S_PRE_RD;
            end
         end
         S_SRCH_INIT: state_in = S_SRCH;
         S_SRCH:      state_in = stat.srch_more ? S_WIN_RD1 : S_DIV;
         S_WIN_RD1:   state_in = S_WIN_RD2;
         S_WIN_RD2:   state_in = S_WIN_SUB;
         S_WIN_SUB:   state_in = S_WIN_WAIT;
         S_WIN_WAIT:  if (stat.mul_done) state_in = stat.sel ? S_CMP_RD : S_WIN_RD1;
         S_CMP_RD:    state_in = S_CMP_CHK;
         S_CMP_CHK: begin
            priority if (stat.cmp_hit) begin
               state_in = S_SRCH;
            end else if (stat.cmp_last) begin
               state_in = stat.win_last ? S_SRCH : S_WIN_RD1;
            end else begin
               state_in = S_CMP_RD;
            end
         end
         S_DIV:       if (stat.div_last) state_in = S_FINISH;
         S_FINISH:    state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.op        = OP_NOP;
      cmd.mul_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // hold a compute while the last result is still waiting
            req_ready = !(stat.rsp_busy && req_action == ACT_COMPUTE);
            if (fire && (req_action == ACT_FIRST || req_action == ACT_SECOND)) begin
               cmd.op = OP_APPEND;
            end
         end
         S_START: cmd.op = OP_START;
         S_POW: begin
            cmd.op        = OP_POW;
            cmd.mul_start = !stat.pow_last;
         end
         S_POW_WAIT: if (stat.mul_done) cmd.op = OP_POW_NEXT;
         S_PRE_CHK:  if (stat.cnt_zero && !stat.sel) cmd.op = OP_PRE_SKIP;
         S_PRE_RD:   cmd.op = OP_NOP;
         S_PRE_ACC:  cmd.op = OP_PRE_ACC;
         S_SRCH_INIT: cmd.op = OP_SRCH_INIT;
         S_SRCH:     cmd.op = stat.srch_more ? OP_MID : OP_DIV_INIT;
         S_WIN_RD1:  cmd.op = OP_WIN_ADDR;
         S_WIN_RD2:  cmd.op = OP_WIN_LATCH;
         S_WIN_SUB:  cmd.mul_start = 1'b1;
         S_WIN_WAIT: if (stat.mul_done) cmd.op = stat.sel ? OP_WIN_HASH : OP_WIN_STORE;
         S_CMP_RD:   cmd.op = OP_NOP;
         S_CMP_CHK: begin
            priority if (stat.cmp_hit) begin
               cmd.op = OP_HIT;
            end else if (stat.cmp_last) begin
               cmd.op = stat.win_last ? OP_MISS : OP_NEXT_POS;
            end else begin
               cmd.op = OP_CMP_NEXT;
            end
         end
         S_DIV:      cmd.op = OP_DIV_STEP;
         S_FINISH:   cmd.op = OP_FINISH;
         default:    cmd.op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
